// ----- sv/dqvd_pkg.sv -----
// Package for the deque with value delete block.
// Holds command codes, status codes, controller states and the command struct.
// No dependencies.
package dqvd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_POP_TAIL  = 3'd2,
    CMD_POP_HEAD  = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_SEARCH    = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture the input item and run the compare.
    logic exec;   // Apply the captured command to the cells.
  } dp_cmd_t;

endpackage

// ----- sv/dqvd_if.sv -----
// Valid/ready channel interface for the deque with value delete block.
// Depends on nothing; payload width is a parameter.
interface dqvd_if #(
  parameter int PW = 8
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/deque_with_value_delete_top.sv -----
// Top level of the deque with value delete block.
// Depends on dqvd_pkg, dqvd_if, dqvd_ctrl and dqvd_dp.
//
//   Channel | Direction | Payload {fields, MSB first}
//   in_ch   | sink      | {cmd[2:0], value[31:0]}
//   out_ch  | source    | {data_out[31:0], found, status[1:0], is_empty, count[4:0]}
//
// Each command is captured and its value compared against all cells at once,
// then the cells are updated and the result registered.
// A new command is taken in the cycle its predecessor's result transfers.
// Reset empties the list; the stored words need no clearing.
// A stalled result holds the block and all fields stay stable.
module deque_with_value_delete_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input logic   clk,
  input logic   rst_n,
  dqvd_if.sink   in_ch,
  dqvd_if.source out_ch
);

  dqvd_pkg::dp_cmd_t dp_cmd;
  logic [31:0] res_data;
  logic        res_found;
  logic [1:0]  res_status;
  logic        res_empty;
  logic [4:0]  res_count;

  dqvd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  dqvd_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .in_cmd     (in_ch.payload[34:32]),
    .in_value   (in_ch.payload[31:0]),
    .res_data   (res_data),
    .res_found  (res_found),
    .res_status (res_status),
    .res_empty  (res_empty),
    .res_count  (res_count)
  );

  assign out_ch.payload = {res_data, res_found, res_status, res_empty, res_count};

endmodule

// ----- sv/dqvd_ctrl.sv -----
// Controller state machine for the deque with value delete block.
// Depends on dqvd_pkg.
module dqvd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output dqvd_pkg::dp_cmd_t  dp_cmd
);

  dqvd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqvd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    dp_cmd.load = 1'b0;
    dp_cmd.exec = 1'b0;
    unique case (state_r)
      dqvd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = dqvd_pkg::S_EXEC;
        end
      end
      dqvd_pkg::S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = dqvd_pkg::S_OUT;
      end
      dqvd_pkg::S_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            dp_cmd.load = 1'b1;
            state_nxt   = dqvd_pkg::S_EXEC;
          end else begin
            state_nxt = dqvd_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = dqvd_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/dqvd_dp.sv -----
// Datapath for the deque with value delete block: cells, count, compare and result.
// Depends on dqvd_pkg.
module dqvd_dp #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dqvd_pkg::dp_cmd_t dp_cmd,
  input  logic [2:0]        in_cmd,
  input  logic [31:0]       in_value,
  output logic [31:0]       res_data,
  output logic              res_found,
  output logic [1:0]        res_status,
  output logic              res_empty,
  output logic [4:0]        res_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_BITS-1:0] cell_r [DEPTH];
  logic [WORD_BITS-1:0] cell_nxt [DEPTH];
  logic [CW-1:0]        count_r, count_nxt;
  logic [2:0]           cmd_r;
  logic [WORD_BITS-1:0] word_r, word_in;
  logic [DEPTH-1:0]     hit_r, hit_in, first_hit;
  logic                 any_hit;
  logic                 full, empty;
  logic [WORD_BITS-1:0] data_nxt;
  logic                 found_nxt;
  logic [1:0]           status_nxt;
  logic [31:0]          data_r;
  logic                 found_r;
  logic [1:0]           status_r;

  assign word_in = WORD_BITS'($signed(in_value));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_in[i] = (cell_r[i] == word_in) && (CW'(i) < count_r);
    end
  end

  always_comb begin
    first_hit = hit_r & ~(hit_r - DEPTH'(1));
  end

  assign any_hit = |hit_r;
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

  always_comb begin
    logic below;
    below      = 1'b0;
    count_nxt  = count_r;
    data_nxt   = '0;
    found_nxt  = 1'b0;
    status_nxt = dqvd_pkg::ST_OK;
    for (int i = 0; i < DEPTH; i++) cell_nxt[i] = cell_r[i];
    unique case (dqvd_pkg::cmd_t'(cmd_r))
      dqvd_pkg::CMD_PUSH_TAIL: begin
        if (full) status_nxt = dqvd_pkg::ST_FULL;
        else begin
          cell_nxt[count_r[IW-1:0]] = word_r;
          count_nxt = count_r + CW'(1);
        end
      end
      dqvd_pkg::CMD_PUSH_HEAD: begin
        if (full) status_nxt = dqvd_pkg::ST_FULL;
        else begin
          for (int i = 1; i < DEPTH; i++) cell_nxt[i] = cell_r[i-1];
          cell_nxt[0] = word_r;
          count_nxt = count_r + CW'(1);
        end
      end
      dqvd_pkg::CMD_POP_TAIL: begin
        if (empty) status_nxt = dqvd_pkg::ST_EMPTY;
        else begin
          count_nxt = count_r - CW'(1);
          data_nxt  = cell_r[count_nxt[IW-1:0]];
        end
      end
      dqvd_pkg::CMD_POP_HEAD: begin
        if (empty) status_nxt = dqvd_pkg::ST_EMPTY;
        else begin
          data_nxt = cell_r[0];
          for (int i = 0; i < DEPTH - 1; i++) cell_nxt[i] = cell_r[i+1];
          count_nxt = count_r - CW'(1);
        end
      end
      dqvd_pkg::CMD_REMOVE: begin
        if (!any_hit) status_nxt = dqvd_pkg::ST_NOT_FOUND;
        else begin
          found_nxt = 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            below = below | first_hit[i];
            if (below) cell_nxt[i] = cell_r[i+1];
          end
          count_nxt = count_r - CW'(1);
        end
      end
      dqvd_pkg::CMD_SEARCH: found_nxt = any_hit;
      dqvd_pkg::CMD_CLEAR:  count_nxt = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r  <= in_cmd;
      word_r <= word_in;
      hit_r  <= hit_in;
    end
    if (dp_cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
      data_r   <= 32'(data_nxt);
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

  assign res_data   = data_r;
  assign res_found  = found_r;
  assign res_status = status_r;
  assign res_empty  = (count_r == '0);
  assign res_count  = 5'(count_r);

endmodule
